// ===== rtl/dnlf_pkg.sv =====
// ----------------------------------------------------------------------------
// DNP3 link frame reassembler package
// Shared result codes, queue sizing and the command passed from the front
// end to the result sequencer.
// ----------------------------------------------------------------------------
package dnlf_pkg;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_EVENT = 2'd2;

   localparam logic [2:0] EV_BAD_FIRST_SIZE  = 3'd0;
   localparam logic [2:0] EV_FIRST_MISSING   = 3'd1;
   localparam logic [2:0] EV_BAD_MIDDLE_SIZE = 3'd2;
   localparam logic [2:0] EV_FINISH_MISSING  = 3'd3;
   localparam logic [2:0] EV_TOO_LONG        = 3'd4;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   // One accepted item turns into at most one such command.
   typedef struct packed {
      logic             ev_head;
      logic [2:0]       ev_code;
      logic             hdr;
      logic [7:0][7:0]  hdr_bytes;
      logic             wr;
      logic [15:0]      wr_off;
      logic [7:0]       wr_val;
      logic             ev_tail;
      logic             patch;
      logic [15:0]      patch_len;
      logic             done;
      logic             dir;
      logic [15:0]      frag_len;
   } cmd_type;

endpackage

// ===== rtl/dnlf_front.sv =====
// ----------------------------------------------------------------------------
// DNP3 link frame reassembler front end
// Tracks the position in each payload, latches the link header, decodes the
// transport byte and turns each item into at most one command for the sequencer.
// ----------------------------------------------------------------------------
module dnlf_front #(
   parameter int FRAGMENT_LIMIT = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic [15:0]       payload_len,
   input  logic              first_of_payload,
   input  logic [15:0]       full_segment_length,
   output logic              push,
   output dnlf_pkg::cmd_type cmd
);
   import dnlf_pkg::*;

   typedef enum logic [1:0] {
      MODE_IGNORE = 2'd0,
      MODE_FIRST  = 2'd1,
      MODE_CONT   = 2'd2,
      MODE_SINGLE = 2'd3
   } mode_type;

   localparam logic [16:0] LIMIT      = 17'(FRAGMENT_LIMIT);
   localparam logic [16:0] FILL_MAX   = 17'h1FFFF;
   localparam logic [7:0]  START0     = 8'h05;
   localparam logic [7:0]  START1     = 8'h64;
   localparam logic [3:0]  FC_CONF    = 4'h3;
   localparam logic [3:0]  FC_UNCONF  = 4'h4;
   localparam logic [15:0] POS_MAX    = 16'hFFFF;
   localparam logic [15:0] POS_XPORT  = 16'd10;
   localparam logic [15:0] MIN_LEN    = 16'd11;
   localparam logic [4:0]  PHASE_LAST = 5'd17;
   localparam logic [4:0]  PHASE_CRC0 = 5'd16;
   localparam logic [4:0]  PHASE_HEAD = 5'd8;

   logic [15:0]     pos_ff, pos_in, pos;
   logic [4:0]      phase_ff, phase_in, phase;
   logic [7:0][7:0] hdr_ff, hdr_in;
   logic            first_seen_ff, first_seen_in;
   logic [16:0]     fill_ff, fill_in;
   mode_type        mode_ff, mode_in;
   logic            dir_ff, dir_in;
   logic            final_ff, final_in;
   logic [16:0]     len17, pos_p1, pos_p2, fill_m2;
   logic [7:0]      ctrl;
   logic            fir, fin;

   assign len17  = {1'b0, payload_len};
   assign pos_p1 = {1'b0, pos} + 17'd1;
   assign pos_p2 = {1'b0, pos} + 17'd2;
   assign ctrl   = hdr_ff[3];
   assign fir    = data_byte[6];
   assign fin    = data_byte[7];

   always_comb begin
      pos           = first_of_payload ? '0 : pos_ff;
      phase         = first_of_payload ? PHASE_HEAD : phase_ff;
      mode_in       = first_of_payload ? MODE_IGNORE : mode_ff;
      hdr_in        = hdr_ff;
      first_seen_in = first_seen_ff;
      fill_in       = fill_ff;
      dir_in        = dir_ff;
      final_in      = final_ff;
      cmd           = '0;
      fill_m2       = '0;

      pos_in   = (pos == POS_MAX) ? pos : pos + 16'd1;
      phase_in = (pos == POS_MAX) ? phase :
                 ((phase == PHASE_LAST) ? 5'd0 : phase + 5'd1);

      if (pos < 16'd8) begin
         hdr_in[pos[2:0]] = data_byte;
      end

      if (payload_len >= MIN_LEN && pos < payload_len) begin
         if (pos == POS_XPORT) begin
            mode_in = MODE_IGNORE;
            if (hdr_ff[0] == START0 && hdr_ff[1] == START1 &&
                (ctrl[3:0] == FC_CONF || ctrl[3:0] == FC_UNCONF)) begin
               dir_in = ctrl[7];
               if (fir && !fin) begin
                  first_seen_in = 1'b1;
                  if (payload_len != full_segment_length) begin
                     cmd.ev_head = 1'b1;
                     cmd.ev_code = EV_BAD_FIRST_SIZE;
                  end else begin
                     cmd.hdr       = 1'b1;
                     cmd.hdr_bytes = hdr_ff;
                     fill_in       = 17'd8;
                     mode_in       = MODE_FIRST;
                     final_in      = 1'b0;
                  end
               end else if (!fir) begin
                  if (!first_seen_ff) begin
                     cmd.ev_head = 1'b1;
                     cmd.ev_code = EV_FIRST_MISSING;
                  end else if (!fin && payload_len != full_segment_length) begin
                     cmd.ev_head = 1'b1;
                     cmd.ev_code = EV_BAD_MIDDLE_SIZE;
                  end else begin
                     mode_in  = MODE_CONT;
                     final_in = fin;
                  end
               end else begin
                  if (first_seen_ff && payload_len != MIN_LEN) begin
                     cmd.ev_head = 1'b1;
                     cmd.ev_code = EV_FINISH_MISSING;
                  end
                  first_seen_in    = 1'b0;
                  cmd.hdr          = 1'b1;
                  cmd.hdr_bytes    = hdr_ff;
                  cmd.hdr_bytes[3] = 8'h00;
                  fill_in          = 17'd8;
                  mode_in          = MODE_SINGLE;
                  final_in         = 1'b1;
               end
            end
         end else if (pos > POS_XPORT && mode_in != MODE_IGNORE && pos_p2 < len17 &&
                      phase != PHASE_CRC0 && phase != PHASE_LAST) begin
            if (fill_in < LIMIT) begin
               cmd.wr     = 1'b1;
               cmd.wr_off = fill_in[15:0];
               cmd.wr_val = data_byte;
            end
            if (fill_in != FILL_MAX) begin
               fill_in = fill_in + 17'd1;
            end
         end

         if (pos_p1 == len17 && mode_in != MODE_IGNORE) begin
            if (final_in && (mode_in == MODE_CONT || mode_in == MODE_SINGLE)) begin
               first_seen_in = 1'b0;
               if (fill_in >= LIMIT) begin
                  cmd.ev_tail = 1'b1;
               end else begin
                  fill_m2 = fill_in - 17'd2;
                  if (mode_in == MODE_CONT) begin
                     cmd.patch     = 1'b1;
                     cmd.patch_len = fill_m2[15:0];
                  end
                  cmd.done     = 1'b1;
                  cmd.dir      = dir_in;
                  cmd.frag_len = fill_in[15:0];
               end
               fill_in = '0;
            end
            mode_in  = MODE_IGNORE;
            final_in = 1'b0;
         end
      end
   end

   assign push = accept && (cmd.ev_head || cmd.hdr || cmd.wr || cmd.ev_tail ||
                            cmd.patch || cmd.done);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         phase_ff      <= PHASE_HEAD;
         first_seen_ff <= 1'b0;
         fill_ff       <= '0;
         mode_ff       <= MODE_IGNORE;
         dir_ff        <= 1'b0;
         final_ff      <= 1'b0;
      end else if (accept) begin
         pos_ff        <= pos_in;
         phase_ff      <= phase_in;
         first_seen_ff <= first_seen_in;
         fill_ff       <= fill_in;
         mode_ff       <= mode_in;
         dir_ff        <= dir_in;
         final_ff      <= final_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff <= hdr_in;
      end
   end

endmodule

// ===== rtl/dnlf_fifo.sv =====
// ----------------------------------------------------------------------------
// DNP3 link frame reassembler command queue
// Short first-in first-out store that decouples the front end from the
// result sequencer.
// ----------------------------------------------------------------------------
module dnlf_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dnlf_pkg::cmd_type push_cmd,
   input  logic              pop,
   output dnlf_pkg::cmd_type head_cmd,
   output logic              empty,
   output logic              full
);
   import dnlf_pkg::*;

   cmd_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("Command pushed into a full queue.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("Command popped from an empty queue.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("Queue occupancy exceeds its depth.");

endmodule

// ===== rtl/dnlf_back.sv =====
// ----------------------------------------------------------------------------
// DNP3 link frame reassembler result sequencer
// Expands the command at the head of the queue into result items, one per
// cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module dnlf_back (
   input  logic                               clock,
   input  logic                               reset,
   input  dnlf_pkg::cmd_type                  head_cmd,
   input  logic                               empty,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dnlf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast
);
   import dnlf_pkg::*;

   localparam int         NUM_SLOTS     = 14;
   localparam logic [3:0] SLOT_EV_HEAD  = 4'd0;
   localparam logic [3:0] SLOT_HDR_LAST = 4'd8;
   localparam logic [3:0] SLOT_WR       = 4'd9;
   localparam logic [3:0] SLOT_EV_TAIL  = 4'd10;
   localparam logic [3:0] SLOT_PATCH_LO = 4'd11;
   localparam logic [3:0] SLOT_PATCH_HI = 4'd12;

   logic                   loaded_ff;
   logic [NUM_SLOTS-1:0]   mask_ff;
   logic [NUM_SLOTS-1:0]   en, cur, low, rest;
   logic [3:0]             idx;
   logic [2:0]             hk;
   logic                   advance;
   logic                   rsp_tvalid_ff, rsp_tlast_ff;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff;
   logic [1:0]             rsp_tuser_ff;
   logic [1:0]             kind;
   logic [15:0]            off;
   logic [7:0]             val;
   logic                   fm;
   logic [15:0]            flen;
   logic [2:0]             code;

   assign en = {head_cmd.done, head_cmd.patch, head_cmd.patch, head_cmd.ev_tail,
                head_cmd.wr, {8{head_cmd.hdr}}, head_cmd.ev_head};
   assign cur     = loaded_ff ? mask_ff : en;
   assign low     = cur & (~cur + 1'b1);
   assign rest    = cur & ~low;
   assign advance = !empty && (!rsp_tvalid_ff || rsp_tready);
   assign pop     = advance && (rest == '0);
   assign hk      = 3'(idx - 4'd1);

   always_comb begin
      idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (cur[i]) begin
            idx = 4'(i);
         end
      end
   end

   always_comb begin
      kind = KIND_WRITE;
      off  = '0;
      val  = '0;
      fm   = 1'b0;
      flen = '0;
      code = '0;
      priority if (idx == SLOT_EV_HEAD) begin
         kind = KIND_EVENT;
         code = head_cmd.ev_code;
      end else if (idx <= SLOT_HDR_LAST) begin
         off = {13'd0, hk};
         val = head_cmd.hdr_bytes[hk];
      end else if (idx == SLOT_WR) begin
         off = head_cmd.wr_off;
         val = head_cmd.wr_val;
      end else if (idx == SLOT_EV_TAIL) begin
         kind = KIND_EVENT;
         code = EV_TOO_LONG;
      end else if (idx == SLOT_PATCH_LO) begin
         off = 16'd2;
         val = head_cmd.patch_len[7:0];
      end else if (idx == SLOT_PATCH_HI) begin
         off = 16'd3;
         val = head_cmd.patch_len[15:8];
      end else begin
         kind = KIND_DONE;
         fm   = head_cmd.dir;
         flen = head_cmd.frag_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= 1'b0;
         mask_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_tvalid_ff <= 1'b1;
            loaded_ff     <= (rest != '0);
            mask_ff       <= rest;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_tdata_ff <= {4'd0, code, flen, fm, val, off};
         rsp_tuser_ff <= kind;
         rsp_tlast_ff <= (rest == '0);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ===== rtl/dnp3_link_frame_reassembler_core.sv =====
// ----------------------------------------------------------------------------
// DNP3 link frame reassembler
// Deframes DNP3-over-TCP payload bytes and emits offset-addressed fragment
// buffer writes, completion results and anomaly events.
//
//   Channel  Direction  Contents
//   req_     in         one payload byte with its payload length and start flag
//   rsp_     out        byte write, fragment completion or anomaly event
//   csr_     in         full segment length register write
//
// One byte is accepted per cycle while the command queue has room.
// A byte yields up to nine results, which the sequencer sends one per cycle
// while the output is not stalled. A header burst of eight writes holds the
// sequencer, so back-to-back bytes fill the four-entry command queue and stall
// the input, for longer when an anomaly event leads the burst.
// Results pass through the command queue and the registered output stage.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dnp3_link_frame_reassembler_core #(
   parameter int FRAGMENT_LIMIT = 65536
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [7:0] data_byte, [23:8] payload_len
   input  logic [dnlf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] first_of_payload
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] buffer_offset, [23:16] byte_value, [24] from_master,
   // [40:25] fragment_length, [43:41] event_code, [47:44] zero
   output logic [dnlf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [15:0]                        csr_data
);
   import dnlf_pkg::*;

   logic [15:0] seg_len_ff;
   logic        accept, push, pop, empty, full;
   cmd_type     push_cmd, head_cmd;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_len_ff <= 16'd292;
      end else if (csr_valid) begin
         seg_len_ff <= csr_data;
      end
   end

   dnlf_front #(
      .FRAGMENT_LIMIT(FRAGMENT_LIMIT)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .data_byte           (req_tdata[7:0]),
      .payload_len         (req_tdata[23:8]),
      .first_of_payload    (req_tuser),
      .full_segment_length (seg_len_ff),
      .push                (push),
      .cmd                 (push_cmd)
   );

   dnlf_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (empty),
      .full     (full)
   );

   dnlf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
